// File: hw/rtl/row_vector_pearson_correlation_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the row/vector correlation unit
// Shared concurrent assertion forms; compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ROW_VECTOR_PEARSON_CORRELATION_UNIT_DEFINES_SVH
`define ROW_VECTOR_PEARSON_CORRELATION_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CPC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CPC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define CPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: hw/rtl/cpc_pkg.sv
// ---------------------------------------------------------------------------
// Correlation unit package
// Widths, codes and the row snapshot passed from front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_LENGTH  = 256;
   localparam int LEN_BITS    = $clog2(MAX_LENGTH);
   localparam int SUM_BITS    = SAMPLE_BITS + LEN_BITS;
   localparam int SQ_BITS     = 2 * SAMPLE_BITS + LEN_BITS;
   localparam int COL_BITS    = 8;
   localparam int NLEN_BITS   = 9;
   localparam int ROW_BITS    = 8;
   localparam int CORR_BITS   = 16;

   // effective length clamp
   localparam int MAX_N_INT = (MAX_LENGTH < 256) ? MAX_LENGTH : 256;
   localparam logic [NLEN_BITS-1:0] MAX_N = NLEN_BITS'(MAX_N_INT);

   // back-end arithmetic
   localparam int TERM_BITS = SQ_BITS + NLEN_BITS + 2;
   localparam int MAG_BITS  = SQ_BITS + LEN_BITS;
   localparam int PROD_BITS = 2 * MAG_BITS + 2 * CORR_BITS;
   localparam int QBITS     = CORR_BITS;
   localparam int QIDX_BITS = $clog2(QBITS);
   localparam logic [QBITS-1:0] Q_MAX     = QBITS'(32768);
   localparam logic [QBITS-1:0] Q_POS_MAX = QBITS'(32767);

   // queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // register map
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] REG_VECTOR_LENGTH = '0;
   localparam logic [NLEN_BITS-1:0] VECTOR_LENGTH_RESET = NLEN_BITS'(256);

   typedef enum logic {
      OP_LOAD_REF = 1'b0,
      OP_ROW      = 1'b1
   } op_type;

   localparam logic STATUS_VALID     = 1'b0;
   localparam logic STATUS_UNDEFINED = 1'b1;

   typedef struct packed {
      logic [ROW_BITS-1:0]  row_number;
      logic [NLEN_BITS-1:0] n;
      logic [SUM_BITS-1:0]  row_sum;
      logic [SQ_BITS-1:0]   row_square_sum;
      logic [SQ_BITS-1:0]   cross_sum;
      logic [SUM_BITS-1:0]  ref_sum;
      logic [SQ_BITS-1:0]   ref_square_sum;
   } snap_type;

endpackage

`default_nettype wire

// File: hw/rtl/row_vector_pearson_correlation_unit.sv
// ---------------------------------------------------------------------------
// Row/vector Pearson correlation unit
// Correlates each streamed matrix row with a stored reference vector and
// returns r in signed Q1.15 per row.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  req_operation, req_column, req_sample
//   rsp       out        rsp_valid/rsp_stall  rsp_row_number, rsp_correlation, rsp_status
//   csr       in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// The front takes one element per cycle while not stalled; for a row with no
// variance the result passes through the queue and the back's IDLE, PROD, TERM,
// CHECK and OUT states. The back's work on a full row end is set by the shift-add
// multiplier; a two-entry queue lets a following row accumulate meanwhile.
// Reset is synchronous; vector_length resets to 256. The front stalls only
// when a row end finds the queue full.
// ---------------------------------------------------------------------------
`default_nettype none

module row_vector_pearson_correlation_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic [cpc_pkg::COL_BITS-1:0]           req_column,
   input  logic signed [cpc_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [cpc_pkg::ROW_BITS-1:0]           rsp_row_number,
   output logic signed [cpc_pkg::CORR_BITS-1:0]   rsp_correlation,
   output logic                                   rsp_status,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [cpc_pkg::CSR_ADDR_BITS-1:0]      paddr,
   input  logic [cpc_pkg::CSR_DATA_BITS-1:0]      pwdata,
   output logic [cpc_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                                   pready
);
   import cpc_pkg::*;

   logic [NLEN_BITS-1:0] vector_length_ff;
   logic                 push;
   logic                 pop;
   logic                 queue_full;
   logic                 queue_empty;
   snap_type             push_data;
   snap_type             pop_data;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr == REG_VECTOR_LENGTH) ? CSR_DATA_BITS'(vector_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= VECTOR_LENGTH_RESET;
      end else if (psel && penable && pwrite && pready && paddr == REG_VECTOR_LENGTH) begin
         vector_length_ff <= pwdata[NLEN_BITS-1:0];
      end
   end

   cpc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .vector_length (vector_length_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_column    (req_column),
      .req_sample    (req_sample),
      .push          (push),
      .push_data     (push_data),
      .queue_full    (queue_full)
   );

   cpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   cpc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .pop             (pop),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_number  (rsp_row_number),
      .rsp_correlation (rsp_correlation),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

// File: hw/rtl/cpc_front.sv
// ---------------------------------------------------------------------------
// Correlation front end
// Accepts elements, keeps the reference vector and accumulates row sums.
// ---------------------------------------------------------------------------
`default_nettype none

module cpc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [cpc_pkg::NLEN_BITS-1:0]        vector_length,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [cpc_pkg::COL_BITS-1:0]         req_column,
   input  logic signed [cpc_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                 push,
   output cpc_pkg::snap_type                    push_data,
   input  logic                                 queue_full
);
   import cpc_pkg::*;

   logic [SAMPLE_BITS-1:0]        ref_mem [MAX_LENGTH];
   logic [NLEN_BITS-1:0]          n_eff;
   logic                          accept;
   logic                          take;
   logic                          fire;

   logic                          s1_valid_ff;
   op_type                        s1_op_ff;
   logic                          s1_first_ff;
   logic                          s1_last_ff;
   logic [NLEN_BITS-1:0]          s1_n_ff;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff;
   logic signed [SAMPLE_BITS-1:0] y_ff;

   logic [SUM_BITS-1:0]  ref_sum_ff, ref_sum_in;
   logic [SQ_BITS-1:0]   ref_sq_ff, ref_sq_in;
   logic [SUM_BITS-1:0]  row_sum_ff, row_sum_in;
   logic [SQ_BITS-1:0]   row_sq_ff, row_sq_in;
   logic [SQ_BITS-1:0]   cross_ff, cross_in;
   logic [ROW_BITS-1:0]  row_counter_ff, row_counter_in;

   logic signed [2*SAMPLE_BITS-1:0] xx;
   logic signed [2*SAMPLE_BITS-1:0] xy;

   // clamp the configured length
   always_comb begin
      if (vector_length == '0) begin
         n_eff = NLEN_BITS'(1);
      end else if (vector_length > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = vector_length;
      end
   end

   assign accept    = req_valid && !req_stall;
   assign take      = accept && ({1'b0, req_column} < n_eff);
   assign fire      = s1_valid_ff && !(s1_op_ff == OP_ROW && s1_last_ff && queue_full);
   assign req_stall = s1_valid_ff && !fire;

   // reference store: write on vector load, registered read for row elements
   always_ff @(posedge clock) begin
      if (take && op_type'(req_operation) == OP_LOAD_REF) begin
         ref_mem[req_column] <= req_sample;
      end
      if (take) begin
         y_ff <= ref_mem[req_column];
      end
   end

   // stage 1 holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
      if (take) begin
         s1_op_ff    <= op_type'(req_operation);
         s1_first_ff <= (req_column == '0);
         s1_last_ff  <= ({1'b0, req_column} == n_eff - NLEN_BITS'(1));
         s1_n_ff     <= n_eff;
         s1_x_ff     <= req_sample;
      end
   end

   assign xx = s1_x_ff * s1_x_ff;
   assign xy = s1_x_ff * y_ff;

   // accumulator updates
   always_comb begin
      ref_sum_in     = ref_sum_ff;
      ref_sq_in      = ref_sq_ff;
      row_sum_in     = row_sum_ff;
      row_sq_in      = row_sq_ff;
      cross_in       = cross_ff;
      row_counter_in = row_counter_ff;
      if (fire) begin
         if (s1_op_ff == OP_LOAD_REF) begin
            ref_sum_in = (s1_first_ff ? '0 : ref_sum_ff) + SUM_BITS'(s1_x_ff);
            ref_sq_in  = (s1_first_ff ? '0 : ref_sq_ff) + SQ_BITS'(xx);
            if (s1_first_ff) begin
               row_counter_in = '0;
            end
         end else begin
            row_sum_in = (s1_first_ff ? '0 : row_sum_ff) + SUM_BITS'(s1_x_ff);
            row_sq_in  = (s1_first_ff ? '0 : row_sq_ff) + SQ_BITS'(xx);
            cross_in   = (s1_first_ff ? '0 : cross_ff) + SQ_BITS'(xy);
            if (s1_last_ff) begin
               row_counter_in = row_counter_ff + ROW_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_sum_ff     <= '0;
         ref_sq_ff      <= '0;
         row_sum_ff     <= '0;
         row_sq_ff      <= '0;
         cross_ff       <= '0;
         row_counter_ff <= '0;
      end else begin
         ref_sum_ff     <= ref_sum_in;
         ref_sq_ff      <= ref_sq_in;
         row_sum_ff     <= row_sum_in;
         row_sq_ff      <= row_sq_in;
         cross_ff       <= cross_in;
         row_counter_ff <= row_counter_in;
      end
   end

   // row end snapshot into the queue
   assign push = fire && s1_op_ff == OP_ROW && s1_last_ff;
   always_comb begin
      push_data.row_number     = row_counter_ff;
      push_data.n              = s1_n_ff;
      push_data.row_sum        = row_sum_in;
      push_data.row_square_sum = row_sq_in;
      push_data.cross_sum      = cross_in;
      push_data.ref_sum        = ref_sum_ff;
      push_data.ref_square_sum = ref_sq_ff;
   end

endmodule

`default_nettype wire

// File: hw/rtl/cpc_queue.sv
// ---------------------------------------------------------------------------
// Row snapshot queue
// Short FIFO decoupling the accumulating front from the arithmetic back.
// ---------------------------------------------------------------------------
`default_nettype none
`include "row_vector_pearson_correlation_unit_defines.svh"

module cpc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cpc_pkg::snap_type push_data,
   output logic              full,
   input  logic              pop,
   output cpc_pkg::snap_type pop_data,
   output logic              empty
);
   import cpc_pkg::*;

   snap_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QCNT_BITS-1:0]   count_ff;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + QPTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_BITS'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_BITS'(1);
         end
      end
   end

   `CPC_ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !full, "push into full queue")
   `CPC_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, !empty, "pop from empty queue")
   `CPC_ASSERT_NEXT(a_push_lands, clock, reset, push && !pop, !empty, "pushed entry lost")

endmodule

`default_nettype wire

// File: hw/rtl/cpc_back.sv
// ---------------------------------------------------------------------------
// Correlation back end
// Forms the variance and covariance terms, then finds r in Q1.15 with a
// bit-by-bit search driven by a shared shift-add multiplier.
// ---------------------------------------------------------------------------
`default_nettype none
`include "row_vector_pearson_correlation_unit_defines.svh"

module cpc_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 queue_empty,
   output logic                                 pop,
   input  cpc_pkg::snap_type                    pop_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cpc_pkg::ROW_BITS-1:0]         rsp_row_number,
   output logic signed [cpc_pkg::CORR_BITS-1:0] rsp_correlation,
   output logic                                 rsp_status
);
   import cpc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_TERM,
      ST_CHECK,
      ST_MUL_DEN,
      ST_MUL_NUM,
      ST_SRCH_SETUP,
      ST_SRCH_MUL,
      ST_SRCH_CMP,
      ST_FINISH,
      ST_OUT
   } state_type;

   state_type state_ff;
   snap_type  snap_ff;

   logic signed [TERM_BITS-1:0] p_nxx_ff, sxx_ff, p_nyy_ff, syy_ff, p_nxy_ff, sxy_ff;
   logic signed [TERM_BITS-1:0] vx_ff, vy_ff, num_ff;
   logic signed [TERM_BITS-1:0] num_abs;
   logic                        num_neg_ff;
   logic [MAG_BITS-1:0]         num_mag_ff;

   // shift-add multiplier
   logic [PROD_BITS-1:0] acc_ff;
   logic [PROD_BITS-1:0] mcand_ff;
   logic [MAG_BITS-1:0]  mplier_ff;
   logic [PROD_BITS-1:0] den_ff;
   logic [PROD_BITS-1:0] lim_ff;

   // search
   logic [QBITS-1:0]     q_ff;
   logic [QBITS-1:0]     t_ff;
   logic [QIDX_BITS-1:0] bit_ff;
   logic [QBITS-1:0]     t_try;
   logic [QBITS:0]       k_odd;
   logic [2*QBITS+1:0]   k_sq;

   logic [ROW_BITS-1:0]         res_row_ff;
   logic signed [CORR_BITS-1:0] res_corr_ff;
   logic                        res_status_ff;
   logic                        rsp_valid_ff;
   logic [ROW_BITS-1:0]         rsp_row_ff;
   logic signed [CORR_BITS-1:0] rsp_corr_ff;
   logic                        rsp_status_ff;

   assign pop     = (state_ff == ST_IDLE) && !queue_empty;
   assign num_abs = num_ff[TERM_BITS-1] ? -num_ff : num_ff;
   assign t_try   = q_ff | (QBITS'(1) << bit_ff);
   assign k_odd   = {t_try, 1'b0} - (QBITS+1)'(1);
   assign k_sq    = k_odd * k_odd;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_number  = rsp_row_ff;
   assign rsp_correlation = rsp_corr_ff;
   assign rsp_status      = rsp_status_ff;

   // sequencer with datapath and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result taken; ST_OUT handles its own reload
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!queue_empty) begin
                  snap_ff  <= pop_data;
                  state_ff <= ST_PROD;
               end
            end
            ST_PROD: begin
               p_nxx_ff <= TERM_BITS'($signed({1'b0, snap_ff.n}) * $signed(snap_ff.row_square_sum));
               p_nyy_ff <= TERM_BITS'($signed({1'b0, snap_ff.n}) * $signed(snap_ff.ref_square_sum));
               p_nxy_ff <= TERM_BITS'($signed({1'b0, snap_ff.n}) * $signed(snap_ff.cross_sum));
               sxx_ff   <= TERM_BITS'($signed(snap_ff.row_sum) * $signed(snap_ff.row_sum));
               syy_ff   <= TERM_BITS'($signed(snap_ff.ref_sum) * $signed(snap_ff.ref_sum));
               sxy_ff   <= TERM_BITS'($signed(snap_ff.row_sum) * $signed(snap_ff.ref_sum));
               state_ff <= ST_TERM;
            end
            ST_TERM: begin
               vx_ff    <= p_nxx_ff - sxx_ff;
               vy_ff    <= p_nyy_ff - syy_ff;
               num_ff   <= p_nxy_ff - sxy_ff;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               res_row_ff <= snap_ff.row_number;
               if (vx_ff <= 0 || vy_ff <= 0) begin
                  res_corr_ff   <= '0;
                  res_status_ff <= STATUS_UNDEFINED;
                  state_ff      <= ST_OUT;
               end else begin
                  num_neg_ff <= num_ff[TERM_BITS-1];
                  num_mag_ff <= num_abs[MAG_BITS-1:0];
                  acc_ff     <= '0;
                  mcand_ff   <= PROD_BITS'(vx_ff[MAG_BITS-1:0]);
                  mplier_ff  <= vy_ff[MAG_BITS-1:0];
                  state_ff   <= ST_MUL_DEN;
               end
            end
            ST_MUL_DEN, ST_MUL_NUM, ST_SRCH_MUL: begin
               if (mplier_ff == '0) begin
                  if (state_ff == ST_MUL_DEN) begin
                     den_ff    <= acc_ff;
                     acc_ff    <= '0;
                     mcand_ff  <= PROD_BITS'(num_mag_ff);
                     mplier_ff <= num_mag_ff;
                     state_ff  <= ST_MUL_NUM;
                  end else if (state_ff == ST_MUL_NUM) begin
                     // scale num^2 by 2^32 for the Q1.15 rounding test
                     lim_ff   <= {acc_ff[PROD_BITS-2*CORR_BITS-1:0], {2*CORR_BITS{1'b0}}};
                     q_ff     <= '0;
                     bit_ff   <= QIDX_BITS'(QBITS - 1);
                     state_ff <= ST_SRCH_SETUP;
                  end else begin
                     state_ff <= ST_SRCH_CMP;
                  end
               end else begin
                  if (mplier_ff[0]) begin
                     acc_ff <= acc_ff + mcand_ff;
                  end
                  mcand_ff  <= {mcand_ff[PROD_BITS-2:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[MAG_BITS-1:1]};
               end
            end
            ST_SRCH_SETUP: begin
               if (t_try > Q_MAX) begin
                  if (bit_ff == '0) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     bit_ff <= bit_ff - QIDX_BITS'(1);
                  end
               end else begin
                  t_ff      <= t_try;
                  acc_ff    <= '0;
                  mcand_ff  <= den_ff;
                  mplier_ff <= MAG_BITS'(k_sq);
                  state_ff  <= ST_SRCH_MUL;
               end
            end
            ST_SRCH_CMP: begin
               // keep the candidate when (2t-1)^2 * den <= num^2 * 2^32
               if (acc_ff <= lim_ff) begin
                  q_ff <= t_ff;
               end
               if (bit_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  bit_ff   <= bit_ff - QIDX_BITS'(1);
                  state_ff <= ST_SRCH_SETUP;
               end
            end
            ST_FINISH: begin
               if (num_neg_ff) begin
                  res_corr_ff <= CORR_BITS'('0 - q_ff);
               end else if (q_ff > Q_POS_MAX) begin
                  res_corr_ff <= Q_POS_MAX;
               end else begin
                  res_corr_ff <= q_ff;
               end
               res_status_ff <= STATUS_VALID;
               state_ff      <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_row_ff    <= res_row_ff;
                  rsp_corr_ff   <= res_corr_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `CPC_ASSERT_IMPLIES(a_q_range, clock, reset, state_ff == ST_FINISH, q_ff <= Q_MAX, "search result out of range")
   `CPC_ASSERT_IMPLIES(a_undef_zero, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_UNDEFINED, rsp_corr_ff == '0, "undefined result not zero")

endmodule

`default_nettype wire
